### rtl/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, silenced while reset is high
`define BQCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent implies consequent in the next cycle
`define BQCS_ASSERT_NEXT(label, ante, cons, msg) \
   `BQCS_ASSERT(label, (ante) |=> (cons), msg)

// Antecedent implies consequent in the same cycle
`define BQCS_ASSERT_SAME(label, ante, cons, msg) \
   `BQCS_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/bqcs_pkg.sv
// Shared constants, types and functions of the Bayer quad component split.
package bqcs_pkg;

   // curve table geometry
   localparam int CURVE_INDEX_BITS = 16;
   localparam int CURVE_DEPTH      = 1 << CURVE_INDEX_BITS;
   localparam int SAMPLE_BITS      = 16;

   // sample format codes
   localparam logic [1:0] FMT_12_UNPACKED = 2'd0;
   localparam logic [1:0] FMT_12_PACKED   = 2'd1;
   localparam logic [1:0] FMT_14          = 2'd2;
   localparam logic [1:0] FMT_16          = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_BAYER_ORDER   = 2'd1;
   localparam logic [1:0] CSR_CURVE_BYPASS  = 2'd2;

   // item kinds carried in req_tuser
   localparam logic MODE_PROCESS = 1'b0;
   localparam logic MODE_WRITE   = 1'b1;

   // curve table write, broadcast to every lane's copy
   typedef struct packed {
      logic                        en;
      logic [CURVE_INDEX_BITS-1:0] addr;
      logic [SAMPLE_BITS-1:0]      data;
   } curve_wr_type;

   // four colour components of one quad after the curve
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green_one;
      logic [SAMPLE_BITS-1:0] green_two;
      logic [SAMPLE_BITS-1:0] blue;
   } quad_type;

   // one result item
   typedef struct packed {
      logic [15:0] blue_minus_green;
      logic [15:0] red_minus_green;
      logic [15:0] green_difference;
      logic [15:0] green_sum;
   } result_type;

   // unpack one row word into {second, first}
   function automatic logic [31:0] unpack_pair(input logic [31:0] word,
                                               input logic [1:0]  fmt);
      logic [15:0] first;
      logic [15:0] second;
      first  = 16'd0;
      second = 16'd0;
      case (fmt)
         FMT_12_PACKED: begin
            first  = {4'd0, word[11:8], word[7:0]};
            second = {4'd0, word[23:16], word[15:12]};
         end
         FMT_14: begin
            first  = {2'd0, word[13:0]};
            second = {2'd0, word[29:16]};
         end
         FMT_16: begin
            first  = word[15:0];
            second = word[31:16];
         end
         default: begin
            first  = {4'd0, word[11:0]};
            second = {4'd0, word[27:16]};
         end
      endcase
      return {second, first};
   endfunction

endpackage

### rtl/bqcs_lane.sv
// One lane: a private copy of the curve table and the per-sample lookup.
module bqcs_lane (
   input  logic                                 clock,
   input  bqcs_pkg::curve_wr_type               wr,
   input  logic                                 load,
   input  logic [bqcs_pkg::SAMPLE_BITS-1:0]     sample,
   input  logic                                 bypass,
   output logic [bqcs_pkg::SAMPLE_BITS-1:0]     value
);

   logic [bqcs_pkg::SAMPLE_BITS-1:0] curve_mem_ff [bqcs_pkg::CURVE_DEPTH];
   logic [bqcs_pkg::SAMPLE_BITS-1:0] rd_data_ff;
   logic [bqcs_pkg::SAMPLE_BITS-1:0] sample_ff;

   // table write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         curve_mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read, raw sample kept alongside for bypass
   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff <= curve_mem_ff[sample[bqcs_pkg::CURVE_INDEX_BITS-1:0]];
         sample_ff  <= sample;
      end
   end

   assign value = bypass ? sample_ff : rd_data_ff;

endmodule

### rtl/bqcs_merge.sv
// Merging stage: forms green sum and the three offset differences, clamped.
module bqcs_merge (
   input  logic                     clock,
   input  logic                     load,
   input  logic [1:0]               fmt,
   input  bqcs_pkg::quad_type       quad,
   output bqcs_pkg::result_type     result
);

   logic [15:0]          max_val;
   logic [17:0]          mid2;
   logic [16:0]          green_add;
   logic [15:0]          green_half;
   logic [17:0]          diff_g;
   logic [17:0]          diff_r;
   logic [17:0]          diff_b;
   bqcs_pkg::result_type result_in;
   bqcs_pkg::result_type result_ff;

   // floor halving of an 18-bit signed value, low 16 bits, clamped
   function automatic logic [15:0] half_clamp(input logic [17:0] v,
                                              input logic [15:0] maxv);
      logic [15:0] h;
      h = v[16:1];
      return (h > maxv) ? maxv : h;
   endfunction

   // format maximum and doubled midpoint
   always_comb begin
      case (fmt)
         bqcs_pkg::FMT_14: begin
            max_val = 16'h3fff;
            mid2    = 18'h04000;
         end
         bqcs_pkg::FMT_16: begin
            max_val = 16'hffff;
            mid2    = 18'h10000;
         end
         default: begin
            max_val = 16'h0fff;
            mid2    = 18'h01000;
         end
      endcase
   end

   // component arithmetic
   always_comb begin
      green_add  = {1'b0, quad.green_one} + {1'b0, quad.green_two};
      green_half = green_add[16:1];
      diff_g     = {2'b0, quad.green_one} - {2'b0, quad.green_two} + mid2;
      diff_r     = {2'b0, quad.red} - {2'b0, green_half} + mid2;
      diff_b     = {2'b0, quad.blue} - {2'b0, green_half} + mid2;

      result_in.green_sum        = (green_half > max_val) ? max_val : green_half;
      result_in.green_difference = half_clamp(diff_g, max_val);
      result_in.red_minus_green  = half_clamp(diff_r, max_val);
      result_in.blue_minus_green = half_clamp(diff_b, max_val);
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### rtl/bayer_quad_component_split_top.sv
// Top level of the Bayer quad component split.
//
// Input items arrive on req_*: req_tuser selects a process item (0), which
// carries one 2x2 Bayer quad, or a table write item (1), which loads one
// curve table entry and gives no result. Each process item gives one result
// item on rsp_*: green sum, green difference, red minus green, blue minus
// green. Registers are written through csr_*; the user must write them
// only while the block is idle (the block does not enforce it). An item
// passes the curve table read in the four lanes, then the merging stage.
// One item is taken every cycle while req_tready is high; each lane has its
// own table copy, so a quad's four samples are looked up in the same cycle.
// When rsp_tready is low the result waits in the output register and one
// further item may still enter the lane stage; after that req_tready drops.
// Reset clears the pipeline valids and restores the registers (format
// twelve-bit unpacked, upper row red/green, curve bypassed). The curve
// table is not cleared: entries must be written before use.
`include "assert_macros.svh"

module bayer_quad_component_split_top (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // upper_row_pair [31:0], lower_row_pair [63:32],
   // table_address [79:64], table_value [95:80]
   input  logic [95:0] req_tdata,
   // mode [0]
   input  logic        req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // green_sum [15:0], green_difference [31:16],
   // red_minus_green [47:32], blue_minus_green [63:48]
   output logic [63:0] rsp_tdata,
   // configuration
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata
);

   logic [1:0]              fmt_ff;
   logic [1:0]              fmt_in;
   logic                    order_ff;
   logic                    order_in;
   logic                    bypass_ff;
   logic                    bypass_in;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    out_adv;
   logic                    req_fire;
   logic [31:0]             upper_pair;
   logic [31:0]             lower_pair;
   logic [15:0]             lane_sample [4];
   logic [15:0]             lane_value  [4];
   bqcs_pkg::curve_wr_type  curve_wr;
   bqcs_pkg::quad_type      quad;
   bqcs_pkg::result_type    result;

   // configuration registers
   always_comb begin
      fmt_in    = fmt_ff;
      order_in  = order_ff;
      bypass_in = bypass_ff;
      if (csr_wen) begin
         unique case (csr_index)
            bqcs_pkg::CSR_SAMPLE_FORMAT: fmt_in    = csr_wdata;
            bqcs_pkg::CSR_BAYER_ORDER:   order_in  = csr_wdata[0];
            bqcs_pkg::CSR_CURVE_BYPASS:  bypass_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= bqcs_pkg::FMT_12_UNPACKED;
         order_ff  <= 1'b1;
         bypass_ff <= 1'b1;
      end else begin
         fmt_ff    <= fmt_in;
         order_ff  <= order_in;
         bypass_ff <= bypass_in;
      end
   end

   // pipeline handshake
   assign out_adv    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_fire && (req_tuser == bqcs_pkg::MODE_PROCESS);
      end
      if (out_adv) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // table write item, broadcast to all lanes
   assign curve_wr.en   = req_fire && (req_tuser == bqcs_pkg::MODE_WRITE);
   assign curve_wr.addr = req_tdata[64 +: bqcs_pkg::CURVE_INDEX_BITS];
   assign curve_wr.data = req_tdata[95:80];

   // unpack and place samples: lane 0 red, 1 green one, 2 green two, 3 blue
   assign upper_pair = bqcs_pkg::unpack_pair(req_tdata[31:0], fmt_ff);
   assign lower_pair = bqcs_pkg::unpack_pair(req_tdata[63:32], fmt_ff);

   always_comb begin
      if (order_ff) begin
         lane_sample[0] = upper_pair[15:0];
         lane_sample[1] = upper_pair[31:16];
         lane_sample[2] = lower_pair[15:0];
         lane_sample[3] = lower_pair[31:16];
      end else begin
         lane_sample[0] = lower_pair[15:0];
         lane_sample[1] = upper_pair[15:0];
         lane_sample[2] = lower_pair[31:16];
         lane_sample[3] = upper_pair[31:16];
      end
   end

   // curve lanes
   for (genvar g = 0; g < 4; g++) begin : g_lane
      bqcs_lane u_lane (
         .clock  (clock),
         .wr     (curve_wr),
         .load   (req_tready),
         .sample (lane_sample[g]),
         .bypass (bypass_ff),
         .value  (lane_value[g])
      );
   end

   assign quad.red       = lane_value[0];
   assign quad.green_one = lane_value[1];
   assign quad.green_two = lane_value[2];
   assign quad.blue      = lane_value[3];

   // merging stage and output register
   bqcs_merge u_merge (
      .clock  (clock),
      .load   (out_adv),
      .fmt    (fmt_ff),
      .quad   (quad),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {result.blue_minus_green, result.red_minus_green,
                        result.green_difference, result.green_sum};

   // checks on the pipeline control
   `BQCS_ASSERT_NEXT(a_lane_moves_to_empty_out,
      s1_valid_ff && !out_valid_ff, out_valid_ff,
      "lane stage item did not reach empty output")
   `BQCS_ASSERT_NEXT(a_write_gives_no_result,
      req_fire && (req_tuser == bqcs_pkg::MODE_WRITE), !s1_valid_ff,
      "table write item entered the result pipeline")
   `BQCS_ASSERT_NEXT(a_taken_output_empties,
      out_valid_ff && rsp_tready && !s1_valid_ff, !out_valid_ff,
      "result repeated after being taken")

endmodule

### sim/bayer_quad_component_split_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Bayer quad component split: directed and random quads.
module bayer_quad_component_split_top_tb;
   import bqcs_pkg::*;

   // one input item, fields as the block sees them
   typedef struct {
      logic        mode;
      logic [31:0] upper;
      logic [31:0] lower;
      logic [15:0] addr;
      logic [15:0] value;
   } quad_item_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // upper_row_pair [31:0], lower_row_pair [63:32],
   // table_address [79:64], table_value [95:80]
   logic [95:0] req_tdata  = '0;
   // mode [0]
   logic        req_tuser  = MODE_PROCESS;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // green_sum [15:0], green_difference [31:16],
   // red_minus_green [47:32], blue_minus_green [63:48]
   logic [63:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [1:0]  csr_wdata  = '0;

   // shadow of the block's registers and curve table
   logic [1:0]  fmt_shadow    = FMT_12_UNPACKED;
   logic        order_shadow  = 1'b1;
   logic        bypass_shadow = 1'b1;
   logic [15:0] curve_shadow [0:CURVE_DEPTH-1];
   bit          curve_loaded [0:CURVE_DEPTH-1];
   logic [15:0] loaded_addrs [$];

   // components still owed by the block, oldest first
   result_type  components_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors        = 0;
   int quads_sent    = 0;
   int writes_sent   = 0;
   int results_seen  = 0;

   bayer_quad_component_split_top uut (.*);

   always #6 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // largest value a sample may take in a format
   function automatic logic [15:0] format_max(input logic [1:0] fmt);
      case (fmt)
         FMT_14:  return 16'h3FFF;
         FMT_16:  return 16'hFFFF;
         default: return 16'h0FFF;
      endcase
   endfunction

   // two samples out of one row word
   function automatic void unpack_row(input logic [31:0] w, output logic [15:0] first,
                                      output logic [15:0] second);
      logic [15:0] maxv;
      maxv = format_max(fmt_shadow);
      if (fmt_shadow == FMT_12_PACKED) begin
         first  = {4'd0, w[11:0]};
         second = {4'd0, w[23:12]};
      end else begin
         first  = w[15:0] & maxv;
         second = w[31:16] & maxv;
      end
   endfunction

   function automatic logic [15:0] through_curve(input logic [15:0] s);
      return bypass_shadow ? s : curve_shadow[s];
   endfunction

   // floor halving, wrap to 16 bits, clamp
   function automatic logic [15:0] halve_clamp(input int v, input logic [15:0] maxv);
      int          h;
      logic [15:0] t;
      h = v >>> 1;
      t = h[15:0];
      return (t > maxv) ? maxv : t;
   endfunction

   // expected components of one quad under the current settings
   function automatic result_type split_components(input logic [31:0] upper,
                                                   input logic [31:0] lower);
      logic [15:0] maxv, u0, u1, l0, l1, red, g1, g2, blue, gs;
      int          mid2, s;
      result_type  res;
      maxv = format_max(fmt_shadow);
      mid2 = int'(maxv) + 1;
      unpack_row(upper, u0, u1);
      unpack_row(lower, l0, l1);
      if (order_shadow) begin
         red = u0; g1 = u1; g2 = l0; blue = l1;
      end else begin
         g1 = u0; blue = u1; red = l0; g2 = l1;
      end
      red  = through_curve(red);
      g1   = through_curve(g1);
      g2   = through_curve(g2);
      blue = through_curve(blue);
      s  = g1 + g2;
      gs = s[16:1];
      res.green_sum        = (gs > maxv) ? maxv : gs;
      res.green_difference = halve_clamp(int'(g1) - int'(g2) + mid2, maxv);
      res.red_minus_green  = halve_clamp(int'(red) - int'(gs) + mid2, maxv);
      res.blue_minus_green = halve_clamp(int'(blue) - int'(gs) + mid2, maxv);
      return res;
   endfunction

   // update the shadow state for an accepted item
   function automatic void apply_item(input quad_item_t it);
      if (it.mode == MODE_WRITE) begin
         curve_shadow[it.addr] = it.value;
         if (!curve_loaded[it.addr]) loaded_addrs.push_back(it.addr);
         curve_loaded[it.addr] = 1'b1;
         writes_sent++;
      end else begin
         components_due.push_back(split_components(it.upper, it.lower));
         quads_sent++;
      end
   endfunction

   // row word carrying two samples, unused bits random
   function automatic logic [31:0] encode_row(input logic [15:0] first,
                                              input logic [15:0] second);
      logic [31:0] w;
      w = $urandom;
      case (fmt_shadow)
         FMT_12_PACKED: w[23:0] = {second[11:0], first[11:0]};
         FMT_14: begin
            w[13:0]  = first[13:0];
            w[29:16] = second[13:0];
         end
         FMT_16: w = {second, first};
         default: begin
            w[11:0]  = first[11:0];
            w[27:16] = second[11:0];
         end
      endcase
      return w;
   endfunction

   // sample value; with the curve on, only loaded entries are used
   function automatic logic [15:0] pick_sample(input logic [15:0] maxv);
      logic [15:0] a;
      if (bypass_shadow) begin
         case ($urandom_range(7))
            0:       return 16'd0;
            1:       return maxv;
            default: return 16'($urandom) & maxv;
         endcase
      end
      for (int i = 0; i < 16; i++) begin
         a = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
         if (a <= maxv) return a;
      end
      return 16'd0;
   endfunction

   function automatic logic [15:0] pick_table_value();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // send one item; tvalid stays high into the next call unless it idles
   task automatic send_item(input quad_item_t it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {it.value, it.addr, it.lower, it.upper};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_item(it);
   endtask

   task automatic send_rows(input logic [31:0] upper, input logic [31:0] lower);
      quad_item_t it;
      it.mode  = MODE_PROCESS;
      it.upper = upper;
      it.lower = lower;
      it.addr  = 16'($urandom);
      it.value = 16'($urandom);
      send_item(it);
   endtask

   task automatic send_quad(input logic [15:0] u0, input logic [15:0] u1,
                            input logic [15:0] l0, input logic [15:0] l1);
      send_rows(encode_row(u0, u1), encode_row(l0, l1));
   endtask

   task automatic send_table_write(input logic [15:0] addr, input logic [15:0] value);
      quad_item_t it;
      it.mode  = MODE_WRITE;
      it.upper = $urandom;
      it.lower = $urandom;
      it.addr  = addr;
      it.value = value;
      send_item(it);
   endtask

   // wait for every owed result, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (components_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all three registers, block idle
   task automatic set_config(input logic [1:0] fmt, input logic order, input logic bypass);
      csr_wen   <= 1'b1;
      csr_index <= CSR_SAMPLE_FORMAT;
      csr_wdata <= fmt;
      @(posedge clock);
      fmt_shadow = fmt;
      csr_index <= CSR_BAYER_ORDER;
      csr_wdata <= {1'($urandom_range(1)), order};
      @(posedge clock);
      order_shadow = order;
      csr_index <= CSR_CURVE_BYPASS;
      csr_wdata <= {1'($urandom_range(1)), bypass};
      @(posedge clock);
      bypass_shadow = bypass;
      csr_wen <= 1'b0;
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // compare one result item with the oldest expectation
   task automatic check_components(input result_type got);
      result_type want;
      results_seen++;
      if (components_due.size() == 0) begin
         errors++;
         $display("%0t: result with none expected, expected nothing, got %h", $time, got);
         return;
      end
      want = components_due.pop_front();
      report_field("green_sum", want.green_sum, got.green_sum);
      report_field("green_difference", want.green_difference, got.green_difference);
      report_field("red_minus_green", want.red_minus_green, got.red_minus_green);
      report_field("blue_minus_green", want.blue_minus_green, got.blue_minus_green);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_components(rsp_tdata);
   end

   // defaults after reset: 12-bit unpacked, red first, curve bypassed
   task automatic test_reset_state();
      send_rows(32'h0000_0000, 32'h0000_0000);
      send_rows(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_rows(32'hF000_FFFF, 32'hFFFF_0000);
      drain();
   endtask

   // load curve entries at the format edges and at two inner addresses
   task automatic test_curve_load();
      send_table_write(16'h0000, 16'hFFFF);
      send_table_write(16'h0FFF, 16'h0000);
      send_table_write(16'h3FFF, 16'h8000);
      send_table_write(16'hFFFF, 16'hFFFF);
      send_table_write(16'h0AAA, 16'h5555);
      send_table_write(16'h1555, 16'hAAAA);
      drain();
   endtask

   // every format, both orders, curve on and off, extreme samples
   task automatic test_formats_and_orders();
      set_config(FMT_12_UNPACKED, 1'b0, 1'b0);
      send_quad(16'h0FFF, 16'h0000, 16'h0AAA, 16'h0FFF);
      send_quad(16'h0000, 16'h0000, 16'h0000, 16'h0FFF);
      drain();
      // unused top byte set in packed form
      set_config(FMT_12_PACKED, 1'b1, 1'b1);
      send_rows(32'hFFFF_FFFF, 32'h0000_0000);
      send_rows(32'hA55A_5AA5, 32'h5AA5_A55A);
      drain();
      set_config(FMT_14, 1'b0, 1'b1);
      send_quad(16'h3FFF, 16'h0000, 16'h0000, 16'h3FFF);
      send_rows(32'hFFFF_FFFF, 32'hC000_C000);
      drain();
      set_config(FMT_14, 1'b1, 1'b0);
      send_quad(16'h3FFF, 16'h0000, 16'h0AAA, 16'h1555);
      drain();
      set_config(FMT_16, 1'b1, 1'b0);
      send_quad(16'hFFFF, 16'hFFFF, 16'h0000, 16'h3FFF);
      drain();
      set_config(FMT_16, 1'b0, 1'b1);
      send_rows(32'hFFFF_0000, 32'h0000_FFFF);
      send_rows(32'hFFFF_FFFF, 32'h0000_0000);
      drain();
   endtask

   // random quads and table writes over changing settings
   task automatic run_random_phase(input int send_pct, input int recv_pct);
      logic [15:0] maxv;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int seg = 0; seg < 8; seg++) begin
         drain();
         set_config(2'(seg), seg[2], 1'($urandom_range(1)));
         maxv = format_max(fmt_shadow);
         for (int n = 0; n < 56; n++) begin
            if ($urandom_range(6) == 0) begin
               // half the writes land inside the current format's range
               if ($urandom_range(1))
                  send_table_write(16'($urandom_range(maxv)), pick_table_value());
               else
                  send_table_write(16'($urandom), pick_table_value());
            end else begin
               send_quad(pick_sample(maxv), pick_sample(maxv),
                         pick_sample(maxv), pick_sample(maxv));
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_curve_load();
      test_formats_and_orders();
      run_random_phase(37, 82);
      run_random_phase(82, 37);
      run_random_phase(0, 0);
      drain();
      repeat (8) @(posedge clock);
      $display("summary: %0d quads, %0d curve table writes, %0d results compared",
               quads_sent, writes_sent, results_seen);
      $display("summary: all four sample formats, both Bayer orders, curve on and off");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/bqcs_pkg.sv
rtl/bqcs_lane.sv
rtl/bqcs_merge.sv
rtl/bayer_quad_component_split_top.sv
sim/bayer_quad_component_split_top_tb.sv
